FILE: rtl/ispc_pkg.sv
// shared types, codes and reset values for the index stream primitive counter
package ispc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int IDX_W           = 32;
  localparam int CAP_W           = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_INDEX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VTX_LIMIT       = 3'd4;

  typedef enum logic [2:0] {
    TOPO_POINTS     = 3'd0,
    TOPO_LINES      = 3'd1,
    TOPO_LINE_STRIP = 3'd2,
    TOPO_LINE_LOOP  = 3'd3,
    TOPO_TRI_LIST   = 3'd4,
    TOPO_TRI_STRIP  = 3'd5,
    TOPO_TRI_FAN    = 3'd6
  } topo_t;

  localparam topo_t              RST_TOPOLOGY       = TOPO_TRI_LIST;
  localparam logic               RST_RESTART_ENABLE = 1'b0;
  localparam logic [IDX_W-1:0]   RST_RESTART_INDEX  = '1;
  localparam logic [IDX_W-1:0]   RST_BASE_OFFSET    = '0;
  localparam logic [CAP_W-1:0]   RST_CAPACITY       = '1;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] vertex_total;
    logic [31:0] primitive_total;
    logic        status;
    logic [31:0] error_position;
  } out_word_t;

  // classification of one index
  typedef struct packed {
    logic is_restart;
    logic in_range;
  } ispc_class_t;

endpackage

FILE: rtl/ispc_classify.sv
// restart match and bound check of one index against the current configuration
module ispc_classify (
  input  logic [ispc_pkg::IDX_W-1:0] index,
  input  logic                       restart_enable,
  input  logic [ispc_pkg::IDX_W-1:0] restart_index,
  input  logic [ispc_pkg::IDX_W-1:0] base_offset,
  input  logic [ispc_pkg::CAP_W-1:0] vtx_limit,
  output ispc_pkg::ispc_class_t      cls
);

  localparam int SUM_W = ispc_pkg::IDX_W + 2;

  logic [SUM_W-1:0] resolved;

  // index is zero-extended, base sign-extended; bit 33 is the sign
  assign resolved = {2'b00, index} + {{2{base_offset[ispc_pkg::IDX_W-1]}}, base_offset};

  always_comb begin
    cls.is_restart = restart_enable && (index == restart_index);
    cls.in_range   = !resolved[SUM_W-1] &&
                     ({{(ispc_pkg::CAP_W-SUM_W){1'b0}}, resolved} < vtx_limit);
  end

endmodule

FILE: rtl/index_stream_primitive_counter.sv
// result path: a last word passes the input register and then the output register,
// and waits in the input register while the previous result still sits unaccepted there
// throughput: one index word per cycle; the counters are updated in one step from
// an input register, and only a last word waits for a full output register
// reset: synchronous active low; configuration returns to its defaults and all
// draw counters clear at once, so words are accepted in the first cycle after reset
module index_stream_primitive_counter #(
  parameter int COUNT_WIDTH = ispc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ispc_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ispc_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [ispc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ispc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = COUNT_WIDTH;

  // configuration
  ispc_pkg::topo_t                topology_r;
  logic                           restart_enable_r;
  logic [ispc_pkg::IDX_W-1:0]     restart_index_r;
  logic [ispc_pkg::IDX_W-1:0]     base_offset_r;
  logic [ispc_pkg::CAP_W-1:0]     capacity_r;

  // input register
  logic                           s1_valid_r;
  ispc_pkg::in_word_t             s1_word_r;

  // draw state
  logic [CW-1:0]                  seg_len_r, seg_len_nxt;
  logic [1:0]                     seg_mod3_r, seg_mod3_nxt;
  logic [CW-1:0]                  seg_q3_r, seg_q3_nxt;
  logic [CW-1:0]                  vcnt_r, vcnt_nxt;
  logic [CW-1:0]                  pcnt_r, pcnt_nxt;
  logic [31:0]                    item_r, item_nxt;
  logic                           err_r, err_nxt;
  logic [31:0]                    err_item_r, err_item_nxt;

  // output register
  logic                           out_valid_r;
  ispc_pkg::out_word_t            out_data_r, out_data_nxt;

  ispc_pkg::ispc_class_t          cls;
  logic                           s1_go;
  logic                           act, take_restart, bad, vtx, close_en;
  logic                           seg_sat;
  logic [CW-1:0]                  seg_inc;
  logic [1:0]                     mod3_inc;
  logic [CW-1:0]                  q3_inc;
  logic [CW-1:0]                  close_n, close_q3;
  logic [CW-1:0]                  prims;
  logic [CW:0]                    p_sum;
  logic [CW-1:0]                  p_close;
  logic                           n_ge2, n_ge3;
  logic [CW-1:0]                  vcnt_upd, pcnt_upd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topology_r       <= ispc_pkg::RST_TOPOLOGY;
      restart_enable_r <= ispc_pkg::RST_RESTART_ENABLE;
      restart_index_r  <= ispc_pkg::RST_RESTART_INDEX;
      base_offset_r    <= ispc_pkg::RST_BASE_OFFSET;
      capacity_r       <= ispc_pkg::RST_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ispc_pkg::CFG_TOPOLOGY:        topology_r       <= ispc_pkg::topo_t'(cfg_data[2:0]);
        ispc_pkg::CFG_RESTART_ENABLE:  restart_enable_r <= cfg_data[0];
        ispc_pkg::CFG_RESTART_INDEX:   restart_index_r  <= cfg_data[ispc_pkg::IDX_W-1:0];
        ispc_pkg::CFG_BASE_OFFSET:     base_offset_r    <= cfg_data[ispc_pkg::IDX_W-1:0];
        ispc_pkg::CFG_VTX_LIMIT:       capacity_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  ispc_classify u_classify (
    .index           (s1_word_r.index),
    .restart_enable  (restart_enable_r),
    .restart_index   (restart_index_r),
    .base_offset     (base_offset_r),
    .vtx_limit       (capacity_r),
    .cls             (cls)
  );

  // only a last word needs room in the output register
  assign s1_go    = s1_valid_r && (!s1_word_r.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
  end

  always_comb begin
    act          = !err_r;
    take_restart = act && cls.is_restart;
    bad          = act && !cls.is_restart && !cls.in_range;
    vtx          = act && !cls.is_restart && cls.in_range;

    // segment length with its quotient and remainder by three kept alongside
    seg_sat  = &seg_len_r;
    seg_inc  = seg_sat ? seg_len_r : seg_len_r + CW'(1);
    mod3_inc = seg_sat ? seg_mod3_r : ((seg_mod3_r == 2'd2) ? 2'd0 : seg_mod3_r + 2'd1);
    q3_inc   = (!seg_sat && (seg_mod3_r == 2'd2)) ? seg_q3_r + CW'(1) : seg_q3_r;

    // a restart closes the old segment; a last vertex closes the grown one
    close_en = take_restart || (s1_word_r.last && vtx);
    close_n  = take_restart ? seg_len_r : seg_inc;
    close_q3 = take_restart ? seg_q3_r  : q3_inc;

    n_ge2 = |close_n[CW-1:1];
    n_ge3 = n_ge2 && (close_n != CW'(2));
    unique case (topology_r)
      ispc_pkg::TOPO_POINTS:     prims = close_n;
      ispc_pkg::TOPO_LINES:      prims = close_n >> 1;
      ispc_pkg::TOPO_LINE_STRIP: prims = n_ge2 ? close_n - CW'(1) : '0;
      ispc_pkg::TOPO_LINE_LOOP:  prims = n_ge2 ? close_n : '0;
      ispc_pkg::TOPO_TRI_LIST:   prims = close_q3;
      ispc_pkg::TOPO_TRI_STRIP,
      ispc_pkg::TOPO_TRI_FAN:    prims = n_ge3 ? close_n - CW'(2) : '0;
      default:                   prims = '0;
    endcase

    p_sum   = {1'b0, pcnt_r} + {1'b0, prims};
    p_close = p_sum[CW] ? '1 : p_sum[CW-1:0];

    pcnt_upd = close_en ? p_close : pcnt_r;
    vcnt_upd = (vtx && !(&vcnt_r)) ? vcnt_r + CW'(1) : vcnt_r;

    err_nxt      = err_r || bad;
    err_item_nxt = bad ? item_r : err_item_r;

    out_data_nxt.status          = err_nxt;
    out_data_nxt.vertex_total    = err_nxt ? 32'd0 : 32'(vcnt_upd);
    out_data_nxt.primitive_total = err_nxt ? 32'd0 : 32'(pcnt_upd);
    out_data_nxt.error_position  = err_nxt ? err_item_nxt : 32'd0;

    if (s1_word_r.last) begin
      seg_len_nxt  = '0;
      seg_mod3_nxt = 2'd0;
      seg_q3_nxt   = '0;
      vcnt_nxt     = '0;
      pcnt_nxt     = '0;
      item_nxt     = '0;
      err_nxt      = 1'b0;
      err_item_nxt = '0;
    end else begin
      vcnt_nxt = vcnt_upd;
      pcnt_nxt = pcnt_upd;
      item_nxt = (&item_r) ? item_r : item_r + 32'd1;
      if (take_restart) begin
        seg_len_nxt  = '0;
        seg_mod3_nxt = 2'd0;
        seg_q3_nxt   = '0;
      end else if (vtx) begin
        seg_len_nxt  = seg_inc;
        seg_mod3_nxt = mod3_inc;
        seg_q3_nxt   = q3_inc;
      end else begin
        seg_len_nxt  = seg_len_r;
        seg_mod3_nxt = seg_mod3_r;
        seg_q3_nxt   = seg_q3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r  <= '0;
      seg_mod3_r <= 2'd0;
      seg_q3_r   <= '0;
      vcnt_r     <= '0;
      pcnt_r     <= '0;
      item_r     <= '0;
      err_r      <= 1'b0;
      err_item_r <= '0;
    end else if (s1_go) begin
      seg_len_r  <= seg_len_nxt;
      seg_mod3_r <= seg_mod3_nxt;
      seg_q3_r   <= seg_q3_nxt;
      vcnt_r     <= vcnt_nxt;
      pcnt_r     <= pcnt_nxt;
      item_r     <= item_nxt;
      err_r      <= err_nxt;
      err_item_r <= err_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_word_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_word_r.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an error result never carries totals
  a_err_zero_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |->
      out_data_r.vertex_total == 32'd0 && out_data_r.primitive_total == 32'd0)
    else $error("error result carries nonzero totals");

  // a finished draw leaves every counter cleared
  a_draw_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_word_r.last |=>
      vcnt_r == '0 && pcnt_r == '0 && item_r == '0 && !err_r && seg_len_r == '0)
    else $error("draw state not cleared after last word");

  // quotient and remainder by three follow the segment length
  a_seg_div3: assert property (@(posedge clk) disable iff (!rst_n)
    seg_mod3_r != 2'd3 && (seg_len_r != '0 || (seg_q3_r == '0 && seg_mod3_r == 2'd0)))
    else $error("segment division state out of step");

  // a segment never holds more vertices than the draw
  a_seg_le_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
    seg_len_r <= vcnt_r)
    else $error("segment length exceeds vertex count");

  // the recorded error position lies before the current word
  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (err_item_r < item_r) || (&item_r))
    else $error("error position not behind current word");

endmodule

FILE: tb/sv/tb_index_stream_primitive_counter.sv
// self-checking testbench for the index stream primitive counter
module tb_index_stream_primitive_counter;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_ITEMS = 1850;
  localparam logic [2:0]  TOPO_UNUSED = 3'd7;
  localparam logic [63:0] CAP_UNLIMITED = '1;

  class draw_totals_board;
    logic [2:0]  topo;
    logic        restart_on;
    logic [31:0] restart_value;
    logic [31:0] base_offset;
    logic [63:0] capacity;
    logic [31:0] seg_len, vertex_cnt, prim_cnt, item_no, err_item;
    logic        err_seen;
    ispc_pkg::out_word_t expected_totals[$];
    int          mismatches;

    function new();
      topo          = ispc_pkg::RST_TOPOLOGY;
      restart_on    = ispc_pkg::RST_RESTART_ENABLE;
      restart_value = ispc_pkg::RST_RESTART_INDEX;
      base_offset   = ispc_pkg::RST_BASE_OFFSET;
      capacity      = ispc_pkg::RST_CAPACITY;
      mismatches    = 0;
      clear_draw();
    endfunction

    function void clear_draw();
      seg_len    = '0;
      vertex_cnt = '0;
      prim_cnt   = '0;
      item_no    = '0;
      err_seen   = 1'b0;
      err_item   = '0;
    endfunction

    function void set_reg(logic [ispc_pkg::CFG_IDX_W-1:0] idx,
                          logic [ispc_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        ispc_pkg::CFG_TOPOLOGY:       topo = d[2:0];
        ispc_pkg::CFG_RESTART_ENABLE: restart_on = d[0];
        ispc_pkg::CFG_RESTART_INDEX:  restart_value = d[31:0];
        ispc_pkg::CFG_BASE_OFFSET:    base_offset = d[31:0];
        ispc_pkg::CFG_VTX_LIMIT:      capacity = d;
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function logic [31:0] segment_prims(logic [31:0] n);
      case (topo)
        ispc_pkg::TOPO_POINTS:     return n;
        ispc_pkg::TOPO_LINES:      return n / 2;
        ispc_pkg::TOPO_LINE_STRIP: return (n >= 2) ? n - 1 : 0;
        ispc_pkg::TOPO_LINE_LOOP:  return (n >= 2) ? n : 0;
        ispc_pkg::TOPO_TRI_LIST:   return n / 3;
        ispc_pkg::TOPO_TRI_STRIP,
        ispc_pkg::TOPO_TRI_FAN:    return (n >= 3) ? n - 2 : 0;
        default:                   return 0;
      endcase
    endfunction

    function void close_segment();
      prim_cnt = sat_add(prim_cnt, segment_prims(seg_len));
      seg_len  = '0;
    endfunction

    function void note_index(ispc_pkg::in_word_t w);
      logic [63:0]         resolved;
      ispc_pkg::out_word_t t;
      if (!err_seen) begin
        if (restart_on && w.index == restart_value) begin
          close_segment();
        end else begin
          // bit 63 set means the signed sum went negative
          resolved = {32'd0, w.index} + {{32{base_offset[31]}}, base_offset};
          if (resolved[63] || resolved >= capacity) begin
            err_seen = 1'b1;
            err_item = item_no;
          end else begin
            seg_len    = sat_add(seg_len, 1);
            vertex_cnt = sat_add(vertex_cnt, 1);
          end
        end
      end
      if (item_no != 32'hFFFF_FFFF) item_no = item_no + 1;
      if (w.last) begin
        if (!err_seen) close_segment();
        t.vertex_total    = err_seen ? '0 : vertex_cnt;
        t.primitive_total = err_seen ? '0 : prim_cnt;
        t.status          = err_seen;
        t.error_position  = err_seen ? err_item : '0;
        expected_totals.insert(expected_totals.size(), t);
        clear_draw();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_totals(ispc_pkg::out_word_t got);
      ispc_pkg::out_word_t want;
      if (expected_totals.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        want = expected_totals.pop_front();
        if (got.vertex_total !== want.vertex_total)
          report($sformatf("vertex_total got %0d want %0d",
                           got.vertex_total, want.vertex_total));
        if (got.primitive_total !== want.primitive_total)
          report($sformatf("primitive_total got %0d want %0d",
                           got.primitive_total, want.primitive_total));
        if (got.status !== want.status)
          report($sformatf("status got %b want %b", got.status, want.status));
        if (got.error_position !== want.error_position)
          report($sformatf("error_position got %0d want %0d",
                           got.error_position, want.error_position));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  ispc_pkg::in_word_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  ispc_pkg::out_word_t             out_data;
  logic                            cfg_we;
  logic [ispc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ispc_pkg::CFG_DATA_W-1:0] cfg_data;

  draw_totals_board sb = new();
  int  sent_words;
  int  burst_left;
  bit  idle_on;

  index_stream_primitive_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the same edge's input word is noted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_totals(out_data);
    if (rst_n && in_valid && in_ready) sb.note_index(in_data);
  end

  // receiver stall pattern
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      repeat (n) @(negedge clk);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_word(logic [31:0] idx, logic last);
    if (burst_left == 0) begin
      if (idle_on) idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ispc_pkg::in_word_t'{index: idx, last: last};
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_words++;
  endtask

  // wait until every pending total has come out and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_totals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [ispc_pkg::CFG_IDX_W-1:0] idx,
                         logic [ispc_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [2:0] topo, logic en, logic [31:0] ridx,
                           logic [31:0] base, logic [63:0] cap);
    set_reg(ispc_pkg::CFG_TOPOLOGY, {61'd0, topo});
    set_reg(ispc_pkg::CFG_RESTART_ENABLE, {63'd0, en});
    set_reg(ispc_pkg::CFG_RESTART_INDEX, {32'd0, ridx});
    set_reg(ispc_pkg::CFG_BASE_OFFSET, {32'd0, base});
    set_reg(ispc_pkg::CFG_VTX_LIMIT, cap);
  endtask

  // mostly an index that resolves inside the buffer, now and then anything
  function automatic logic [31:0] pick_index();
    longint lim, r, bs, idx;
    int     m;
    m = $urandom_range(0, 29);
    if (m == 0) return $urandom();
    if (m <= 4) return $urandom_range(0, 63);
    lim = (sb.capacity > 64'h4_0000_0000) ? 64'sh4_0000_0000 : longint'(sb.capacity);
    if (lim == 0) return $urandom();
    bs = longint'($signed(sb.base_offset));
    if ($urandom_range(0, 2) == 0)
      r = lim - 1 - ($urandom_range(0, 3) % lim);
    else
      r = $urandom_range(0, (lim < 64) ? int'(lim - 1) : 63);
    idx = r - bs;
    if (idx < 0 || idx > 64'sh0_FFFF_FFFF) return $urandom_range(0, 63);
    return idx[31:0];
  endfunction

  task automatic random_config();
    logic [31:0] ridx, base;
    logic [63:0] cap;
    case ($urandom_range(0, 3))
      0:       ridx = '0;
      1:       ridx = '1;
      2:       ridx = $urandom_range(0, 20);
      default: ridx = $urandom();
    endcase
    case ($urandom_range(0, 6))
      0, 1:    base = '0;
      2:       base = $urandom_range(0, 20) - 10;
      3:       base = 32'h8000_0000;
      4:       base = 32'h7FFF_FFFF;
      5:       base = 32'hFFFF_FFC0;
      default: base = $urandom();
    endcase
    case ($urandom_range(0, 6))
      0:       cap = CAP_UNLIMITED;
      1:       cap = 64'd1;
      2, 3:    cap = 64'($urandom_range(1, 40));
      4:       cap = 64'h1_0000_0000;
      5:       cap = {$urandom(), $urandom()};
      default: cap = CAP_UNLIMITED - 64'($urandom_range(0, 3));
    endcase
    write_all(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), ridx, base, cap);
  endtask

  task automatic random_draw();
    int          len;
    logic [31:0] idx;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if (sb.restart_on && $urandom_range(0, 99) < 15) idx = sb.restart_value;
      else idx = pick_index();
      send_word(idx, i == len - 1);
    end
  endtask

  initial begin
    int target;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    sent_words = 0;
    burst_left = 0;
    idle_on    = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one triangle from extreme indices
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd5, 1'b1);
    settle();
    // points with restart, restart word closing the draw
    write_all(ispc_pkg::TOPO_POINTS, 1'b1, 32'd7, 32'd0, CAP_UNLIMITED);
    send_word(32'd1, 1'b0);
    send_word(32'd7, 1'b0);
    send_word(32'd2, 1'b0);
    send_word(32'd7, 1'b1);
    settle();
    // zero capacity: first index already out of range
    write_all(ispc_pkg::TOPO_LINE_LOOP, 1'b0, 32'hFFFF_FFFF, 32'd0, 64'd0);
    send_word(32'd3, 1'b0);
    send_word(32'd4, 1'b1);
    settle();
    // most negative base, error on the bound itself
    write_all(ispc_pkg::TOPO_LINES, 1'b1, 32'd0, 32'h8000_0000, 64'd5);
    send_word(32'h8000_0004, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'h8000_0005, 1'b1);
    settle();
    // unused topology code, most positive base
    write_all(TOPO_UNUSED, 1'b0, 32'd0, 32'h7FFF_FFFF, CAP_UNLIMITED);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b1);
    settle();
    // fan over two segments with capacity one
    write_all(ispc_pkg::TOPO_TRI_FAN, 1'b1, 32'hFFFF_FFFF, 32'd0, 64'd1);
    repeat (4) send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b1);
    settle();

    target = sent_words + RANDOM_ITEMS;
    while (sent_words < target) begin
      random_config();
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 8)) random_draw();
      settle();
    end

    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_totals.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
